### rtl/mwa_pkg.sv
`timescale 1ns / 1ps
// mwa_pkg: shared types and fixed field widths for max_window_average.
// No dependencies.
package mwa_pkg;

  localparam int MAXSUM_W   = 25;
  localparam int AVG_W      = 23;
  localparam int LEN_OUT_W  = 11;
  localparam int CFG_W      = 11;
  localparam int FRAC_W     = 8;
  localparam int OUT_DATA_W = 64;
  localparam int RESET_LEN  = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_CMP,
    ST_PREP,
    ST_DIV,
    ST_SIGN
  } state_t;

endpackage

### rtl/max_window_average.sv
`timescale 1ns / 1ps
// max_window_average: running window sum over a sample stream, best window tracking and
// fixed-point average of the best window (or of a stream shorter than it). Depends on mwa_pkg.
//
// Samples come in on the in_ stream, one word each; a word with in_tlast ends the stream and
// produces one result word. Every sample runs through a sequencer around one shared adder:
// accept (ring read and write), drop oldest, add newest, compare with best, so a sample is
// done before the next is taken and in_tready is high only in the idle state. A last sample
// adds an abs step, a restoring divide of one quotient bit per cycle and a sign step, on the
// same adder. The sample ring is a single memory with one read and one write per sample. The
// result sits in an output register; the sign step waits only if a previous result has not
// been taken. cfg_ready is high in the idle state and a pending write holds in_tready low; a
// write to window_len clamps it to 1..MAX_WINDOW and restarts the stream.
module max_window_average #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 15,
  localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [IN_DATA_W-1:0]               in_tdata,   // sample
  input  logic                               in_tlast,   // last_sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mwa_pkg::OUT_DATA_W-1:0]     out_tdata,  // max_sum, max_average, used_length
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mwa_pkg::CFG_W-1:0]          cfg_data
);

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + PTR_W + 1;
  localparam int NUM_W  = SUM_W + mwa_pkg::FRAC_W;
  localparam int Q_W    = (NUM_W > mwa_pkg::AVG_W) ? NUM_W : mwa_pkg::AVG_W;
  localparam int A1_W   = (SUM_W + 1 > mwa_pkg::AVG_W + 1) ? SUM_W + 1 : mwa_pkg::AVG_W + 1;
  localparam int ALU_W  = (A1_W > LEN_W + 2) ? A1_W : LEN_W + 2;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int WIDE_W = (SUM_W > mwa_pkg::MAXSUM_W) ? SUM_W : mwa_pkg::MAXSUM_W;
  localparam int ULEN_W = (LEN_W > mwa_pkg::LEN_OUT_W) ? LEN_W : mwa_pkg::LEN_OUT_W;
  localparam int RST_LEN = (mwa_pkg::RESET_LEN > MAX_WINDOW) ? MAX_WINDOW : mwa_pkg::RESET_LEN;
  localparam int PAD_W  = mwa_pkg::OUT_DATA_W - mwa_pkg::MAXSUM_W - mwa_pkg::AVG_W
                          - mwa_pkg::LEN_OUT_W;

  mwa_pkg::state_t state_r, state_nxt;

  logic [LEN_W-1:0]              len_r, len_nxt;
  logic [PTR_W-1:0]              ptr_r, ptr_nxt;
  logic [LEN_W-1:0]              fill_r, fill_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [SUM_W-1:0]       best_r, best_nxt;
  logic                          best_valid_r, best_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] s_r, s_nxt;
  logic                          last_r, last_nxt;
  logic                          full_r, full_nxt;
  logic                          neg_r, neg_nxt;
  logic [LEN_W-1:0]              used_r, used_nxt;
  logic [SUM_W-1:0]              msum_r, msum_nxt;
  logic [NUM_W-1:0]              num_r, num_nxt;
  logic [LEN_W-1:0]              rem_r, rem_nxt;
  logic [Q_W-1:0]                q_r, q_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [mwa_pkg::MAXSUM_W-1:0]  osum_r, osum_nxt;
  logic [mwa_pkg::AVG_W-1:0]     oavg_r, oavg_nxt;
  logic [mwa_pkg::LEN_OUT_W-1:0] olen_r, olen_nxt;

  logic [SAMPLE_BITS-1:0]        ring [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_r;

  logic                          in_acc;
  logic [LEN_W:0]                old_ext;
  logic [PTR_W-1:0]              old_addr;
  logic [LEN_W:0]                remsh;
  logic signed [ALU_W-1:0]       alu_a, alu_b, alu_res;
  logic                          alu_sub;
  logic signed [SUM_W-1:0]       msum_sel;
  logic signed [WIDE_W-1:0]      msum_wide;
  logic [ULEN_W-1:0]             used_wide;
  logic [31:0]                   cfg_ext;
  logic                          out_free;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cfg_ext  = 32'(cfg_data);

  always_comb begin
    if ({1'b0, ptr_r} >= (PTR_W + 1)'(len_r)) begin
      old_ext = (LEN_W + 1)'(ptr_r) - (LEN_W + 1)'(len_r);
    end else begin
      old_ext = (LEN_W + 1)'(ptr_r) + (LEN_W + 1)'(MAX_WINDOW) - (LEN_W + 1)'(len_r);
    end
  end
  assign old_addr = old_ext[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring[ptr_r] <= in_tdata[SAMPLE_BITS-1:0];
      rd_r        <= ring[old_addr];
    end
  end

  assign remsh    = {rem_r, num_r[NUM_W-1]};
  assign msum_sel = best_valid_r ? best_r : sum_r;

  // shared adder
  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_r)
      mwa_pkg::ST_SUB: begin
        alu_a = ALU_W'(sum_r);
        alu_b = ALU_W'(rd_r);
      end
      mwa_pkg::ST_ADD: begin
        alu_a   = ALU_W'(sum_r);
        alu_b   = ALU_W'(s_r);
        alu_sub = 1'b0;
      end
      mwa_pkg::ST_CMP: begin
        alu_a = ALU_W'(best_r);
        alu_b = ALU_W'(sum_r);
      end
      mwa_pkg::ST_PREP: begin
        alu_b = ALU_W'(msum_sel);
      end
      mwa_pkg::ST_DIV: begin
        alu_a = ALU_W'(remsh);
        alu_b = ALU_W'(used_r);
      end
      mwa_pkg::ST_SIGN: begin
        alu_b = ALU_W'(q_r[mwa_pkg::AVG_W-1:0]);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign msum_wide = WIDE_W'(signed'(msum_r));
  assign used_wide = ULEN_W'(used_r);

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    ptr_nxt        = ptr_r;
    fill_nxt       = fill_r;
    sum_nxt        = sum_r;
    best_nxt       = best_r;
    best_valid_nxt = best_valid_r;
    s_nxt          = s_r;
    last_nxt       = last_r;
    full_nxt       = full_r;
    neg_nxt        = neg_r;
    used_nxt       = used_r;
    msum_nxt       = msum_r;
    num_nxt        = num_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    osum_nxt       = osum_r;
    oavg_nxt       = oavg_r;
    olen_nxt       = olen_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    in_tready      = 1'b0;
    cfg_ready      = 1'b0;

    case (state_r)
      mwa_pkg::ST_IDLE: begin
        in_tready = !cfg_valid;
        cfg_ready = 1'b1;
        if (cfg_valid) begin
          if (cfg_ext == 32'd0) begin
            len_nxt = LEN_W'(1);
          end else if (cfg_ext > 32'(MAX_WINDOW)) begin
            len_nxt = LEN_W'(MAX_WINDOW);
          end else begin
            len_nxt = LEN_W'(cfg_ext);
          end
          ptr_nxt        = '0;
          fill_nxt       = '0;
          sum_nxt        = '0;
          best_nxt       = '0;
          best_valid_nxt = 1'b0;
        end else if (in_tvalid) begin
          s_nxt    = in_tdata[SAMPLE_BITS-1:0];
          last_nxt = in_tlast;
          full_nxt = fill_r >= len_r;
          ptr_nxt  = (ptr_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_r + PTR_W'(1);
          state_nxt = mwa_pkg::ST_SUB;
        end
      end
      mwa_pkg::ST_SUB: begin
        if (full_r) begin
          sum_nxt = alu_res[SUM_W-1:0];
        end else begin
          fill_nxt = fill_r + LEN_W'(1);
        end
        state_nxt = mwa_pkg::ST_ADD;
      end
      mwa_pkg::ST_ADD: begin
        sum_nxt   = alu_res[SUM_W-1:0];
        state_nxt = mwa_pkg::ST_CMP;
      end
      mwa_pkg::ST_CMP: begin
        if (fill_r == len_r && (!best_valid_r || alu_res[ALU_W-1])) begin
          best_nxt       = sum_r;
          best_valid_nxt = 1'b1;
        end
        state_nxt = last_r ? mwa_pkg::ST_PREP : mwa_pkg::ST_IDLE;
      end
      mwa_pkg::ST_PREP: begin
        msum_nxt = msum_sel;
        neg_nxt  = msum_sel[SUM_W-1];
        used_nxt = best_valid_r ? len_r : fill_r;
        num_nxt  = msum_sel[SUM_W-1] ? {alu_res[SUM_W-1:0], mwa_pkg::FRAC_W'(0)}
                                     : {msum_sel, mwa_pkg::FRAC_W'(0)};
        rem_nxt  = '0;
        q_nxt    = '0;
        cnt_nxt  = CNT_W'(NUM_W);
        state_nxt = mwa_pkg::ST_DIV;
      end
      mwa_pkg::ST_DIV: begin
        if (!alu_res[ALU_W-1]) begin
          rem_nxt = alu_res[LEN_W-1:0];
          q_nxt   = {q_r[Q_W-2:0], 1'b1};
        end else begin
          rem_nxt = remsh[LEN_W-1:0];
          q_nxt   = {q_r[Q_W-2:0], 1'b0};
        end
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = mwa_pkg::ST_SIGN;
        end
      end
      mwa_pkg::ST_SIGN: begin
        if (out_free) begin
          osum_nxt       = msum_wide[mwa_pkg::MAXSUM_W-1:0];
          oavg_nxt       = neg_r ? alu_res[mwa_pkg::AVG_W-1:0] : q_r[mwa_pkg::AVG_W-1:0];
          olen_nxt       = used_wide[mwa_pkg::LEN_OUT_W-1:0];
          out_valid_nxt  = 1'b1;
          ptr_nxt        = '0;
          fill_nxt       = '0;
          sum_nxt        = '0;
          best_nxt       = '0;
          best_valid_nxt = 1'b0;
          state_nxt      = mwa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mwa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mwa_pkg::ST_IDLE;
      len_r        <= LEN_W'(RST_LEN);
      ptr_r        <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      best_r       <= '0;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      ptr_r        <= ptr_nxt;
      fill_r       <= fill_nxt;
      sum_r        <= sum_nxt;
      best_r       <= best_nxt;
      best_valid_r <= best_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    last_r <= last_nxt;
    full_r <= full_nxt;
    neg_r  <= neg_nxt;
    used_r <= used_nxt;
    msum_r <= msum_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    osum_r <= osum_nxt;
    oavg_r <= oavg_nxt;
    olen_r <= olen_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PAD_W'(0), olen_r, oavg_r, osum_r};

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for max_window_average. It drives sample streams and window
// lengths and checks every result word against a scoreboard that tracks windows on its own.
// Depends on mwa_pkg and rtl/max_window_average.sv.
module tb;

  localparam int RING_DEPTH   = 1024;
  localparam int AVG_LSB      = mwa_pkg::MAXSUM_W;
  localparam int LEN_LSB      = mwa_pkg::MAXSUM_W + mwa_pkg::AVG_W;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 5000;
  localparam int ITEM_TARGET  = 1400;

  typedef enum int {
    MIX_FULL,
    MIX_NARROW,
    MIX_NEGATIVE,
    MIX_EXTREME
  } sample_mix_t;

  typedef struct {
    logic [mwa_pkg::MAXSUM_W-1:0]  max_sum;
    logic [mwa_pkg::AVG_W-1:0]     max_avg;
    logic [mwa_pkg::LEN_OUT_W-1:0] used_len;
  } window_result_t;

  class window_scoreboard;
    int unsigned       win_len;
    logic signed [14:0] ring [RING_DEPTH];
    int unsigned       wr_ptr;
    int unsigned       fill;
    longint            run_sum;
    longint            best_sum;
    bit                best_ok;
    window_result_t    result_q[$];
    int                errors;

    function new();
      win_len = mwa_pkg::RESET_LEN;
      errors  = 0;
      restart();
    endfunction

    function void restart();
      wr_ptr   = 0;
      fill     = 0;
      run_sum  = 0;
      best_sum = 0;
      best_ok  = 0;
    endfunction

    function void set_window(logic [mwa_pkg::CFG_W-1:0] v);
      if (v == 0) begin
        win_len = 1;
      end else if (v > RING_DEPTH) begin
        win_len = RING_DEPTH;
      end else begin
        win_len = v;
      end
      restart();
    endfunction

    function void note_sample(logic [14:0] raw, logic last);
      logic signed [14:0] s_val;
      longint         msum;
      longint         used;
      longint         avg;
      window_result_t r;
      s_val = raw;
      if (fill >= win_len) begin
        run_sum -= ring[(wr_ptr + RING_DEPTH - win_len) % RING_DEPTH];
      end else begin
        fill++;
      end
      ring[wr_ptr] = s_val;
      run_sum += s_val;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      if (fill == win_len && (!best_ok || run_sum > best_sum)) begin
        best_sum = run_sum;
        best_ok  = 1;
      end
      if (last) begin
        if (best_ok) begin
          msum = best_sum;
          used = win_len;
        end else begin
          msum = run_sum;
          used = fill;
        end
        avg = (msum * (longint'(1) << mwa_pkg::FRAC_W)) / used;
        r.max_sum  = msum[mwa_pkg::MAXSUM_W-1:0];
        r.max_avg  = avg[mwa_pkg::AVG_W-1:0];
        r.used_len = used[mwa_pkg::LEN_OUT_W-1:0];
        result_q.push_back(r);
        restart();
      end
    endfunction

    function void check_result(logic [mwa_pkg::OUT_DATA_W-1:0] d);
      window_result_t r;
      logic [mwa_pkg::MAXSUM_W-1:0]  got_sum;
      logic [mwa_pkg::AVG_W-1:0]     got_avg;
      logic [mwa_pkg::LEN_OUT_W-1:0] got_len;
      got_sum = d[mwa_pkg::MAXSUM_W-1:0];
      got_avg = d[AVG_LSB +: mwa_pkg::AVG_W];
      got_len = d[LEN_LSB +: mwa_pkg::LEN_OUT_W];
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result word, got max_sum %0d avg %0d len %0d",
                 $time, $signed(got_sum), $signed(got_avg), got_len);
        errors++;
        return;
      end
      r = result_q.pop_front();
      if (got_sum !== r.max_sum) begin
        $display("%0t: max_sum expected %0d got %0d", $time,
                 $signed(r.max_sum), $signed(got_sum));
        errors++;
      end
      if (got_avg !== r.max_avg) begin
        $display("%0t: max_average expected %0d got %0d", $time,
                 $signed(r.max_avg), $signed(got_avg));
        errors++;
      end
      if (got_len !== r.used_len) begin
        $display("%0t: used_length expected %0d got %0d", $time, r.used_len, got_len);
        errors++;
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [15:0]                    in_tdata;   // sample, pad bit
  logic                           in_tlast;   // last_sample
  logic                           out_tvalid;
  logic                           out_tready;
  logic [mwa_pkg::OUT_DATA_W-1:0] out_tdata;  // max_sum, max_average, used_length, pad
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [mwa_pkg::CFG_W-1:0]      cfg_data;

  window_scoreboard sb;
  int gap_pct;
  int stall_pct;
  int sent;
  int idle_cycles;

  max_window_average dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_window(cfg_data);
      end
      if (in_tvalid && in_tready) begin
        sb.note_sample(in_tdata[14:0], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [14:0] pick_sample(sample_mix_t mix);
    int v;
    case (mix)
      MIX_FULL:     v = $urandom;
      MIX_NARROW:   v = int'($urandom_range(400)) - 200;
      MIX_NEGATIVE: v = -int'($urandom_range(16384, 1));
      default:      v = $urandom_range(1) ? 16383 : -16384;
    endcase
    return v[14:0];
  endfunction

  task automatic send_sample(logic [14:0] s, logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, s};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_stream(int n, sample_mix_t mix, bit close);
    for (int i = 0; i < n; i++) begin
      send_sample(pick_sample(mix), close && (i == n - 1));
    end
  endtask

  // sender holds off until every result word is back and the block has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(logic [mwa_pkg::CFG_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned eff;
    int          n;
    int          phase;
    logic [mwa_pkg::CFG_W-1:0] wv;
    sb          = new();
    sent        = 0;
    idle_cycles = 0;
    gap_pct     = 0;
    stall_pct   = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window of 4: extremes, single-sample stream, short and all-negative streams
    send_sample(15'h3fff, 0);
    send_sample(15'h4000, 0);
    send_sample(15'h0000, 0);
    send_sample(15'h7fff, 0);
    send_sample(15'h3fff, 0);
    send_sample(15'h3fff, 1);
    send_sample(15'h4000, 1);
    send_sample(-15'sd5, 0);
    send_sample(-15'sd3, 1);
    send_sample(-15'sd7, 0);
    send_sample(-15'sd2, 0);
    send_sample(-15'sd9, 0);
    send_sample(-15'sd1, 0);
    send_sample(-15'sd4, 1);
    // zero saturates to one
    write_window(11'd0);
    send_sample(-15'sd3, 0);
    send_sample(-15'sd8, 1);
    // oversize saturates to 1024, stream shorter than the window
    write_window(11'h7ff);
    send_sample(15'd100, 0);
    send_sample(-15'sd200, 0);
    send_sample(15'd300, 1);
    // open stream dropped by a window write
    send_sample(15'd5, 0);
    send_sample(15'd6, 0);
    write_window(11'd3);
    send_sample(15'd1, 0);
    send_sample(15'd2, 0);
    send_sample(15'd3, 0);
    send_sample(15'd4, 1);

    phase = 0;
    while (sent < ITEM_TARGET) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 62; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 62; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      if (phase == 3) begin
        wv = 11'h7ff;
      end else if (phase % 10 == 6) begin
        wv = 11'd0;
      end else if (phase % 10 == 9) begin
        wv = 11'd1024;
      end else if (phase % 3 == 0) begin
        wv = mwa_pkg::CFG_W'($urandom_range(40, 9));
      end else begin
        wv = mwa_pkg::CFG_W'($urandom_range(8, 1));
      end
      write_window(wv);
      eff = (wv == 0) ? 1 : (wv > RING_DEPTH) ? RING_DEPTH : wv;
      if (phase == 3) begin
        // full 1024 window with ring wrap
        send_stream(1030 + $urandom_range(20), MIX_NARROW, 1);
      end else begin
        for (int k = 0; k < 4; k++) begin
          if (eff == RING_DEPTH) begin
            n = $urandom_range(40, 1);
          end else if ($urandom_range(99) < 15) begin
            n = $urandom_range(eff, 1);
          end else begin
            n = $urandom_range(3 * eff + 4, eff);
          end
          send_stream(n, sample_mix_t'($urandom_range(3)), 1);
        end
      end
      if ($urandom_range(3) == 0) begin
        send_stream($urandom_range(5, 1), sample_mix_t'($urandom_range(3)), 0);
      end
      phase++;
    end

    // a trailing open stream is discarded by this final write
    write_window(mwa_pkg::CFG_W'(mwa_pkg::RESET_LEN));
    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/mwa_pkg.sv
rtl/max_window_average.sv
sim/tb.sv
